FILE: rtl/core/tcs_pkg.sv
package tcs_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned FREE_W = 5;
  localparam int unsigned CFG_W  = 2;

  // operation codes
  localparam logic [2:0] MODE_BIRTH   = 3'd0;
  localparam logic [2:0] MODE_RETAP   = 3'd1;
  localparam logic [2:0] MODE_UPDATE  = 3'd2;
  localparam logic [2:0] MODE_GRACE   = 3'd3;
  localparam logic [2:0] MODE_KILL    = 3'd4;
  localparam logic [2:0] MODE_EXPIRE  = 3'd5;
  localparam logic [2:0] MODE_GESTURE = 3'd6;

  // slot phases
  localparam logic [1:0] PH_FREE   = 2'd0;
  localparam logic [1:0] PH_ACTIVE = 2'd1;
  localparam logic [1:0] PH_GRACE  = 2'd2;

  // register indexes
  localparam logic [CFG_W-1:0] CFG_DEADZONE = CFG_W'(0);
  localparam logic [CFG_W-1:0] CFG_BLEND    = CFG_W'(1);

  localparam logic [7:0] DEADZONE_RST = 8'd2;
  localparam logic [3:0] BLEND_RST    = 4'd5;
  localparam logic [3:0] BLEND_MAX    = 4'd8;
  localparam logic [7:0] AGE_MAX      = 8'd255;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] ident;
    logic [15:0] rep_x;
    logic [15:0] rep_y;
    logic [15:0] base_x;
    logic [15:0] base_y;
    logic        first;
    logic        gest;
    logic [7:0]  age;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       x;
    logic [15:0]       y;
    logic              alone;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic        take_id;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
  } alu_res_t;

  typedef struct packed {
    logic              status;
    logic [31:0]       contact_id;
    logic [15:0]       out_x;
    logic [15:0]       out_y;
    logic [1:0]        slot_status;
    logic [7:0]        frames_alive;
    logic [FREE_W-1:0] free_slot;
  } result_t;

endpackage

FILE: rtl/core/touch_contact_table_smoother.sv
// Touch contact slot table: birth, retap, update with deadzone and blend
// smoothing, grace, gesture, kill and expiry on 16 slots held in flip-flops.
// One transaction is accepted every cycle while the output is not stalled.
// The input register loads at the accepting edge, and the result register
// loads from it when the output advances, raising out_valid_o.
// The slot table is written at the same edge as the result register, so a
// transaction always sees the effect of the one before it. A stalled output
// holds the input register, which then raises in_stall_o. Configuration
// writes are always ready and must only be issued while the block is idle.
module touch_contact_table_smoother import tcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        mode_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [15:0]       x_coord_i,
  input  logic [15:0]       y_coord_i,
  input  logic              alone_flag_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [31:0]       contact_id_o,
  output logic [15:0]       out_x_o,
  output logic [15:0]       out_y_o,
  output logic [1:0]        slot_status_o,
  output logic [7:0]        frames_alive_o,
  output logic [FREE_W-1:0] free_slot_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  logic              in_valid_q;
  item_t             in_q;
  logic              out_valid_q;
  result_t           out_q, out_d;
  slot_rec_t         rec_q [SLOTS];
  logic [31:0]       ident_q;
  logic [7:0]        deadzone_q;
  logic [3:0]        weight_q;
  logic              adv;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  slot_rec_t         cur, nxt;
  alu_res_t          alu;
  logic [SLOTS-1:0]  free_vec;
  logic [FREE_W-1:0] lowest;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !adv;
  assign cfg_ready_o = 1'b1;

  assign in_range = {1'b0, in_q.slot} < (SLOT_W + 1)'(SLOTS);
  assign idx      = in_q.slot[IDX_W-1:0];
  assign cur      = in_range ? rec_q[idx] : '0;

  tcs_slot_alu u_alu (
    .cur_i       (cur),
    .item_i      (in_q),
    .deadzone_i  (deadzone_q),
    .weight_i    (weight_q),
    .new_ident_i (ident_q + 32'd1),
    .nxt_o       (nxt),
    .res_o       (alu)
  );

  // free map after this transaction, then lowest free slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      if (in_range && idx == IDX_W'(i)) begin
        free_vec[i] = (nxt.phase == PH_FREE);
      end else begin
        free_vec[i] = (rec_q[i].phase == PH_FREE);
      end
    end
    lowest = FREE_W'(SLOTS);
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        lowest = FREE_W'(i);
      end
    end
  end

  always_comb begin
    out_d.free_slot = lowest;
    if (in_range) begin
      out_d.status       = !alu.ok;
      out_d.contact_id   = alu.id;
      out_d.out_x        = alu.x;
      out_d.out_y        = alu.y;
      out_d.slot_status  = nxt.phase;
      out_d.frames_alive = nxt.age;
    end else begin
      out_d.status       = 1'b1;
      out_d.contact_id   = '0;
      out_d.out_x        = '0;
      out_d.out_y        = '0;
      out_d.slot_status  = PH_FREE;
      out_d.frames_alive = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= '{mode: mode_i, slot: slot_i, x: x_coord_i, y: y_coord_i, alone: alone_flag_i};
    end
    if (adv && in_valid_q) begin
      out_q <= out_d;
    end
  end

  // commit slot state as the result register loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        rec_q[i] <= '0;
      end
      ident_q <= '0;
    end else if (adv && in_valid_q && in_range) begin
      rec_q[idx] <= nxt;
      if (alu.take_id) begin
        ident_q <= ident_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      weight_q   <= BLEND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEADZONE: deadzone_q <= cfg_data_i;
        CFG_BLEND:    weight_q   <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign contact_id_o   = out_q.contact_id;
  assign out_x_o        = out_q.out_x;
  assign out_y_o        = out_q.out_y;
  assign slot_status_o  = out_q.slot_status;
  assign frames_alive_o = out_q.frames_alive;
  assign free_slot_o    = out_q.free_slot;

endmodule

FILE: rtl/core/tcs_slot_alu.sv
module tcs_slot_alu import tcs_pkg::*; (
  input  slot_rec_t   cur_i,
  input  item_t       item_i,
  input  logic [7:0]  deadzone_i,
  input  logic [3:0]  weight_i,
  input  logic [31:0] new_ident_i,
  output slot_rec_t   nxt_o,
  output alu_res_t    res_o
);

  logic [3:0]  w;
  logic [15:0] dx, dy;
  logic        passed;
  logic        gest_now;

  function automatic logic [15:0] blend(input logic [15:0] raw, input logic [15:0] prev,
                                        input logic [3:0] wt);
    logic [19:0] sum;
    sum = 20'(raw) * 20'(wt) + 20'(prev) * 20'(BLEND_MAX - wt);
    return sum[18:3];
  endfunction

  assign w  = (weight_i > BLEND_MAX) ? BLEND_MAX : weight_i;
  assign dx = (item_i.x >= cur_i.base_x) ? item_i.x - cur_i.base_x : cur_i.base_x - item_i.x;
  assign dy = (item_i.y >= cur_i.base_y) ? item_i.y - cur_i.base_y : cur_i.base_y - item_i.y;
  assign passed   = cur_i.first || (dx >= {8'd0, deadzone_i}) || (dy >= {8'd0, deadzone_i});
  assign gest_now = cur_i.gest && item_i.alone;

  always_comb begin
    nxt_o         = cur_i;
    res_o.ok      = 1'b0;
    res_o.take_id = 1'b0;
    unique case (item_i.mode) inside
      MODE_BIRTH, MODE_RETAP: begin
        if (cur_i.phase == PH_FREE) begin
          res_o.ok      = 1'b1;
          res_o.take_id = 1'b1;
          nxt_o.phase   = PH_ACTIVE;
          nxt_o.ident   = new_ident_i;
          nxt_o.rep_x   = item_i.x;
          nxt_o.rep_y   = item_i.y;
          nxt_o.base_x  = item_i.x;
          nxt_o.base_y  = item_i.y;
          nxt_o.first   = 1'b1;
          nxt_o.gest    = 1'b0;
          nxt_o.age     = 8'd1;
        end
      end
      MODE_UPDATE: begin
        if (cur_i.phase == PH_ACTIVE) begin
          res_o.ok = 1'b1;
          if (passed) begin
            nxt_o.base_x = item_i.x;
            nxt_o.base_y = item_i.y;
            if (cur_i.first || gest_now) begin
              nxt_o.rep_x = item_i.x;
              nxt_o.rep_y = item_i.y;
              if (gest_now) begin
                nxt_o.gest = 1'b0;
              end
            end else begin
              nxt_o.rep_x = blend(item_i.x, cur_i.rep_x, w);
              nxt_o.rep_y = blend(item_i.y, cur_i.rep_y, w);
            end
          end
          nxt_o.first = 1'b0;
          if (cur_i.age != AGE_MAX) begin
            nxt_o.age = cur_i.age + 8'd1;
          end
        end
      end
      MODE_GRACE: begin
        if (cur_i.phase == PH_ACTIVE) begin
          res_o.ok    = 1'b1;
          nxt_o.phase = PH_GRACE;
        end
      end
      MODE_KILL: begin
        if (cur_i.phase == PH_ACTIVE || cur_i.phase == PH_GRACE) begin
          res_o.ok = 1'b1;
          nxt_o    = '0;
        end
      end
      MODE_EXPIRE: begin
        if (cur_i.phase == PH_GRACE) begin
          res_o.ok = 1'b1;
          nxt_o    = '0;
        end
      end
      MODE_GESTURE: begin
        if (cur_i.phase == PH_ACTIVE) begin
          res_o.ok   = 1'b1;
          nxt_o.gest = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // a kill reports the contact it just dropped
    if (res_o.ok && item_i.mode == MODE_KILL) begin
      res_o.id = cur_i.ident;
      res_o.x  = cur_i.rep_x;
      res_o.y  = cur_i.rep_y;
    end else begin
      res_o.id = nxt_o.ident;
      res_o.x  = nxt_o.rep_x;
      res_o.y  = nxt_o.rep_y;
    end
  end

endmodule

FILE: rtl/core/tcs_checker.sv
module tcs_checker import tcs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [31:0]       contact_id_o,
  input logic [1:0]        slot_status_o,
  input logic [7:0]        frames_alive_o,
  input logic [FREE_W-1:0] free_slot_o
);

  // a free slot never carries an age
  a_free_no_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_status_o == PH_FREE |-> frames_alive_o == 8'd0)
    else $error("free slot reports nonzero frames_alive");

  // a live slot has seen at least its birth frame
  a_active_aged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_status_o == PH_ACTIVE |-> frames_alive_o != 8'd0)
    else $error("active slot reports zero frames_alive");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_slot_o <= FREE_W'(SLOTS))
    else $error("free_slot beyond table");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(contact_id_o))
    else $error("stalled result changed");

endmodule

bind touch_contact_table_smoother tcs_checker u_tcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .contact_id_o   (contact_id_o),
  .slot_status_o  (slot_status_o),
  .frames_alive_o (frames_alive_o),
  .free_slot_o    (free_slot_o)
);

FILE: test/testbench.sv
module testbench;
  import tcs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        mode_i = MODE_BIRTH;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [15:0]       x_coord_i = '0;
  logic [15:0]       y_coord_i = '0;
  logic              alone_flag_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              status_o;
  logic [31:0]       contact_id_o;
  logic [15:0]       out_x_o;
  logic [15:0]       out_y_o;
  logic [1:0]        slot_status_o;
  logic [7:0]        frames_alive_o;
  logic [FREE_W-1:0] free_slot_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_index_i = CFG_DEADZONE;
  logic [7:0]        cfg_data_i = '0;

  touch_contact_table_smoother i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow slot table and registers
  logic [1:0]  tbl_phase  [SLOTS];
  logic [31:0] tbl_ident  [SLOTS];
  logic [15:0] tbl_rep_x  [SLOTS];
  logic [15:0] tbl_rep_y  [SLOTS];
  logic [15:0] tbl_base_x [SLOTS];
  logic [15:0] tbl_base_y [SLOTS];
  logic        tbl_first  [SLOTS];
  logic        tbl_gest   [SLOTS];
  logic [7:0]  tbl_age    [SLOTS];
  logic [31:0] ident_ctr = '0;
  logic [7:0]  cur_deadzone = DEADZONE_RST;
  logic [3:0]  cur_blend = BLEND_RST;

  result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic void clear_entry(int s);
    tbl_phase[s]  = PH_FREE;
    tbl_ident[s]  = '0;
    tbl_rep_x[s]  = '0;
    tbl_rep_y[s]  = '0;
    tbl_base_x[s] = '0;
    tbl_base_y[s] = '0;
    tbl_first[s]  = 1'b0;
    tbl_gest[s]   = 1'b0;
    tbl_age[s]    = '0;
  endfunction

  function automatic logic [FREE_W-1:0] lowest_free_slot();
    for (int i = 0; i < SLOTS; i++)
      if (tbl_phase[i] == PH_FREE) return FREE_W'(i);
    return FREE_W'(SLOTS);
  endfunction

  function automatic logic axis_moved(logic [15:0] raw, logic [15:0] base);
    int d;
    d = int'(raw) - int'(base);
    if (d < 0) d = -d;
    return d >= int'(cur_deadzone);
  endfunction

  function automatic logic [15:0] blend_axis(logic [15:0] raw, logic [15:0] prev, int w);
    int acc;
    acc = int'(raw) * w + int'(prev) * (8 - w);
    return acc[18:3];
  endfunction

  // apply one operation to the shadow table and return what the block must report
  function automatic result_t track_contact(logic [2:0] op, logic [SLOT_W-1:0] s,
                                            logic [15:0] px, logic [15:0] py,
                                            logic alone);
    result_t     r;
    logic        ok;
    logic        passed;
    logic        gest;
    logic [31:0] old_id;
    logic [15:0] old_x;
    logic [15:0] old_y;
    int          w;
    ok     = 1'b0;
    old_id = tbl_ident[s];
    old_x  = tbl_rep_x[s];
    old_y  = tbl_rep_y[s];
    w      = (cur_blend > BLEND_MAX) ? int'(BLEND_MAX) : int'(cur_blend);
    case (op)
      MODE_BIRTH, MODE_RETAP: if (tbl_phase[s] == PH_FREE) begin
        ok            = 1'b1;
        ident_ctr     = ident_ctr + 32'd1;
        tbl_phase[s]  = PH_ACTIVE;
        tbl_ident[s]  = ident_ctr;
        tbl_rep_x[s]  = px;
        tbl_rep_y[s]  = py;
        tbl_base_x[s] = px;
        tbl_base_y[s] = py;
        tbl_first[s]  = 1'b1;
        tbl_gest[s]   = 1'b0;
        tbl_age[s]    = 8'd1;
      end
      MODE_UPDATE: if (tbl_phase[s] == PH_ACTIVE) begin
        ok     = 1'b1;
        passed = tbl_first[s] || axis_moved(px, tbl_base_x[s]) ||
                 axis_moved(py, tbl_base_y[s]);
        if (passed) begin
          gest          = tbl_gest[s] && alone;
          tbl_base_x[s] = px;
          tbl_base_y[s] = py;
          if (tbl_first[s] || gest) begin
            tbl_rep_x[s] = px;
            tbl_rep_y[s] = py;
            if (gest) tbl_gest[s] = 1'b0;
          end else begin
            tbl_rep_x[s] = blend_axis(px, tbl_rep_x[s], w);
            tbl_rep_y[s] = blend_axis(py, tbl_rep_y[s], w);
          end
        end
        tbl_first[s] = 1'b0;
        if (tbl_age[s] != AGE_MAX) tbl_age[s] = tbl_age[s] + 8'd1;
      end
      MODE_GRACE: if (tbl_phase[s] == PH_ACTIVE) begin
        ok           = 1'b1;
        tbl_phase[s] = PH_GRACE;
      end
      MODE_KILL: if (tbl_phase[s] == PH_ACTIVE || tbl_phase[s] == PH_GRACE) begin
        ok = 1'b1;
        clear_entry(s);
      end
      MODE_EXPIRE: if (tbl_phase[s] == PH_GRACE) begin
        ok = 1'b1;
        clear_entry(s);
      end
      MODE_GESTURE: if (tbl_phase[s] == PH_ACTIVE) begin
        ok          = 1'b1;
        tbl_gest[s] = 1'b1;
      end
      default: ;
    endcase
    if (ok && op == MODE_KILL) begin
      r.contact_id = old_id;
      r.out_x      = old_x;
      r.out_y      = old_y;
    end else begin
      r.contact_id = tbl_ident[s];
      r.out_x      = tbl_rep_x[s];
      r.out_y      = tbl_rep_y[s];
    end
    r.status       = ~ok;
    r.slot_status  = tbl_phase[s];
    r.frames_alive = tbl_age[s];
    r.free_slot    = lowest_free_slot();
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %0d at result %0d: %s got %0h want %0h",
               mismatches, results_checked, what, got, want);
  endtask

  // check each result against the oldest expectation, then predict new transactions
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", contact_id_o, 0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (contact_id_o !== want.contact_id)
            report_mismatch("contact_id", contact_id_o, want.contact_id);
          if (out_x_o !== want.out_x)
            report_mismatch("out_x", out_x_o, want.out_x);
          if (out_y_o !== want.out_y)
            report_mismatch("out_y", out_y_o, want.out_y);
          if (slot_status_o !== want.slot_status)
            report_mismatch("slot_status", slot_status_o, want.slot_status);
          if (frames_alive_o !== want.frames_alive)
            report_mismatch("frames_alive", frames_alive_o, want.frames_alive);
          if (free_slot_o !== want.free_slot)
            report_mismatch("free_slot", free_slot_o, want.free_slot);
        end
        results_checked++;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(track_contact(mode_i, slot_i, x_coord_i, y_coord_i,
                                                 alone_flag_i));
        items_sent++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEADZONE: cur_deadzone = cfg_data_i;
          CFG_BLEND:    cur_blend = cfg_data_i[3:0];
          default: ;
        endcase
        reg_writes++;
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_count > 0) begin
      out_stall_i <= 1'b1;
      hold_count--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [2:0] op, logic [SLOT_W-1:0] s, logic [15:0] px,
                           logic [15:0] py, logic alone);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= op;
    slot_i       <= s;
    x_coord_i    <= px;
    y_coord_i    <= py;
    alone_flag_i <= alone;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drop valid and wait until the pipeline has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_register(logic [CFG_W-1:0] idx, logic [7:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly legal lifecycles on random slots, with some raw noise
  task automatic send_random_item();
    logic [2:0]        op;
    logic [SLOT_W-1:0] s;
    logic [15:0]       px;
    logic [15:0]       py;
    logic              alone;
    int                pick;
    int                span;
    s     = SLOT_W'($urandom_range(0, SLOTS - 1));
    px    = 16'($urandom);
    py    = 16'($urandom);
    alone = 1'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      op = 3'($urandom_range(0, 7));
    end else begin
      case (tbl_phase[s])
        PH_FREE: op = pick[0] ? MODE_RETAP : MODE_BIRTH;
        PH_ACTIVE: begin
          if (pick < 70) op = MODE_UPDATE;
          else if (pick < 80) op = MODE_GESTURE;
          else if (pick < 90) op = MODE_GRACE;
          else op = MODE_KILL;
        end
        default: op = (pick < 55) ? MODE_EXPIRE : ((pick < 80) ? MODE_KILL : MODE_UPDATE);
      endcase
    end
    // keep most moves close to the baseline so the deadzone edge gets hit
    if (op == MODE_UPDATE && tbl_phase[s] == PH_ACTIVE && $urandom_range(0, 3) != 0) begin
      span = int'(cur_deadzone) + 3;
      px   = tbl_base_x[s] + 16'($urandom_range(0, 2 * span)) - 16'(span);
      py   = tbl_base_y[s] + 16'($urandom_range(0, 2 * span)) - 16'(span);
    end
    send_item(op, s, px, py, alone);
  endtask

  task automatic send_random_run(int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_lifecycle_basics();
    send_item(MODE_BIRTH,   4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_UPDATE,  4'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(MODE_UPDATE,  4'd0, 16'hFFFE, 16'hFFFF, 1'b1);
    send_item(MODE_UPDATE,  4'd0, 16'h0000, 16'hFFFF, 1'b0);
    send_item(MODE_GESTURE, 4'd0, 16'h1234, 16'h5678, 1'b0);
    send_item(MODE_UPDATE,  4'd0, 16'd100, 16'd200, 1'b0);
    send_item(MODE_UPDATE,  4'd0, 16'd40000, 16'd20, 1'b1);
    send_item(MODE_RETAP,   4'd1, 16'hFFFF, 16'h8000, 1'b1);
    send_item(MODE_BIRTH,   4'd1, 16'h0001, 16'h0001, 1'b0);
    send_item(MODE_UPDATE,  4'd2, 16'h0010, 16'h0010, 1'b0);
    send_item(MODE_GRACE,   4'd2, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_EXPIRE,  4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_GESTURE, 4'd2, 16'h0000, 16'h0000, 1'b0);
    send_item(3'd7,         4'd0, 16'hAAAA, 16'h5555, 1'b1);
    send_item(MODE_GRACE,   4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_UPDATE,  4'd0, 16'h9000, 16'h9000, 1'b1);
    send_item(MODE_GESTURE, 4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_GRACE,   4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_KILL,    4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_EXPIRE,  4'd1, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_GRACE,   4'd1, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_EXPIRE,  4'd1, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_BIRTH,   4'd0, 16'h7FFF, 16'h0001, 1'b0);
    send_item(MODE_KILL,    4'd0, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_KILL,    4'd0, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_age_saturation();
    send_item(MODE_KILL,  4'd15, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_BIRTH, 4'd15, 16'h4000, 16'h4000, 1'b0);
    repeat (258)
      send_item(MODE_UPDATE, 4'd15, tbl_base_x[15] + 16'($urandom_range(0, 8)) - 16'd4,
                tbl_base_y[15] + 16'($urandom_range(0, 8)) - 16'd4, 1'($urandom));
    send_item(MODE_GESTURE, 4'd15, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_UPDATE,  4'd15, 16'hC000, 16'h0100, 1'b1);
  endtask

  task automatic test_table_full();
    for (int s = 0; s < SLOTS; s++)
      send_item(MODE_BIRTH, SLOT_W'(s), 16'($urandom), 16'($urandom), 1'b0);
    send_item(MODE_BIRTH,  4'd3, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_UPDATE, 4'd9, 16'h0000, 16'hFFFF, 1'b0);
    send_item(MODE_KILL,   4'd7, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_RETAP,  4'd7, 16'h0F0F, 16'hF0F0, 1'b0);
    send_item(MODE_GRACE,  4'd2, 16'h0000, 16'h0000, 1'b0);
    send_item(MODE_EXPIRE, 4'd2, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_register(CFG_DEADZONE, 8'd0);
    set_register(CFG_BLEND, 8'd0);
    send_random_run(120);
    set_register(CFG_DEADZONE, 8'd255);
    set_register(CFG_BLEND, 8'd8);
    send_random_run(120);
    // weight above eight saturates; upper data bits are not part of the register
    set_register(CFG_DEADZONE, 8'd1);
    set_register(CFG_BLEND, 8'hFC);
    send_random_run(120);
  endtask

  task automatic test_backpressure();
    set_register(CFG_DEADZONE, DEADZONE_RST);
    set_register(CFG_BLEND, 8'(BLEND_RST));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_count     = HOLD_CYCLES;
    send_random_run(40);
  endtask

  task automatic test_idle_phases();
    set_register(CFG_DEADZONE, 8'd3);
    set_register(CFG_BLEND, 8'd5);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_run(280);
    set_register(CFG_DEADZONE, 8'd2);
    set_register(CFG_BLEND, 8'h36);
    send_idle_pct  = 75;
    recv_stall_pct = 0;
    send_random_run(280);
    set_register(CFG_DEADZONE, 8'd16);
    set_register(CFG_BLEND, 8'd7);
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    send_random_run(280);
    set_register(CFG_DEADZONE, 8'd5);
    set_register(CFG_BLEND, 8'd15);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    send_random_run(280);
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) clear_entry(s);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_lifecycle_basics();
    test_age_saturation();
    test_table_full();
    test_register_extremes();
    test_backpressure();
    test_idle_phases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("expectations left over", expected_results.size(), 0);
    $display("covered %0d transactions in, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("lifecycles, table full, age saturation, register extremes, long hold-off");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: touch_contact_table_smoother.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_slot_alu.sv
rtl/core/touch_contact_table_smoother.sv
rtl/core/tcs_checker.sv
test/testbench.sv
